// ===== hw/rtl/hvd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvd_pkg
// Shared widths, constants and helper functions of the haversine distance
// pipeline.
// ----------------------------------------------------------------------------
package hvd_pkg;

    // Angle in 5e-8 degree units entering a sine/cosine lane
    localparam int ANG_W = 34;
    // Internal width for the angle wrap and fold
    localparam int WRAP_W = 36;
    // Rotation CORDIC datapath widths
    localparam int XY_W = 34;
    localparam int Z_W  = 33;
    // Vectoring CORDIC x and y width
    localparam int VXY_W = 33;
    // Number of CORDIC micro-rotations and square root digits
    localparam int CORDIC_ITER = 31;
    // Square root operand and result widths
    localparam int OP_W   = 31;
    localparam int ROOT_W = 31;
    localparam int REM_W  = 33;
    // Angle output of the vectoring stage, clamped to non-negative
    localparam int ANGLE_W = 31;
    // Radius register width and distance width
    localparam int RADIUS_W = 23;
    localparam int DIST_W   = 25;

    localparam logic signed [WRAP_W-1:0] TURN_HALF_UNITS = 36'sd7200000000;
    localparam logic signed [WRAP_W-1:0] HALF_TURN       = 36'sd3600000000;
    localparam logic signed [WRAP_W-1:0] QUARTER_TURN    = 36'sd1800000000;
    localparam logic [31:0]              RAD_SCALE       = 32'd4024455254;
    localparam logic signed [XY_W-1:0]   CORDIC_GAIN     = 34'sd652032875;
    localparam logic [OP_W-1:0]          Q30_ONE         = 31'd1073741824;
    localparam logic [RADIUS_W-1:0]      RADIUS_RESET    = 23'd6371000;
    localparam logic [DIST_W-1:0]        DIST_MAX        = {DIST_W{1'b1}};

    // Arctangent table in Q30, rounded to nearest
    localparam logic signed [Z_W-1:0] ATAN_TABLE [10] = '{
        33'sd843314857, 33'sd497837829, 33'sd263043837, 33'sd133525159,
        33'sd67021687,  33'sd33543516,  33'sd16775851,  33'sd8388437,
        33'sd4194283,   33'sd2097149
    };

    // Arctangent of 2^-idx in Q30
    function automatic logic signed [Z_W-1:0] atan_q30(input int idx);
        logic signed [Z_W-1:0] res;
        if (idx < 10) begin
            res = ATAN_TABLE[idx];
        end else begin
            res = Z_W'(64'sd1 <<< (30 - idx));
        end
        return res;
    endfunction

    // Bring a Q60 product back to Q30, rounding half away from zero
    function automatic logic signed [XY_W-1:0] q30_round(input logic signed [63:0] p);
        logic [63:0]             mag;
        logic [63:0]             rnd;
        logic signed [XY_W-1:0]  res;
        mag = p[63] ? 64'(-p) : 64'(p);
        rnd = (mag + 64'd536870912) >> 30;
        res = XY_W'(rnd);
        if (p[63]) begin
            res = -res;
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/hvd_sincos.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvd_sincos
// One sine/cosine lane: wraps the angle to one turn, folds it into the
// right half plane, scales it to Q30 radians and runs a pipelined rotation
// CORDIC, one micro-rotation per stage.
// ----------------------------------------------------------------------------
module hvd_sincos (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic signed [hvd_pkg::ANG_W-1:0]  i_angle,
    output logic                              o_valid,
    output logic signed [hvd_pkg::XY_W-1:0]   o_sin,
    output logic signed [hvd_pkg::XY_W-1:0]   o_cos
);

    localparam int N = hvd_pkg::CORDIC_ITER;

    logic signed [hvd_pkg::WRAP_W-1:0] h;
    logic signed [hvd_pkg::WRAP_W-1:0] wrapped;
    logic signed [hvd_pkg::WRAP_W-1:0] folded;
    logic                              fold;
    logic [hvd_pkg::WRAP_W-1:0]        mag_full;

    logic        r_a_valid;
    logic [30:0] r_a_mag;
    logic        r_a_neg;
    logic        r_a_fold;

    logic        r_b_valid;
    logic [62:0] r_b_prod;
    logic        r_b_neg;
    logic        r_b_fold;

    logic [63:0]                     rnd_sum;
    logic signed [hvd_pkg::Z_W-1:0]  z_init;

    logic                             r_v    [0:N];
    logic                             r_fold [0:N];
    logic signed [hvd_pkg::XY_W-1:0]  r_x    [0:N];
    logic signed [hvd_pkg::XY_W-1:0]  r_y    [0:N];
    logic signed [hvd_pkg::Z_W-1:0]   r_z    [0:N];

    // Wrap to one turn, then fold into [-90, 90] degrees
    always_comb begin
        h = hvd_pkg::WRAP_W'(i_angle);
        if (h > hvd_pkg::HALF_TURN) begin
            wrapped = h - hvd_pkg::TURN_HALF_UNITS;
        end else if (h < -hvd_pkg::HALF_TURN) begin
            wrapped = h + hvd_pkg::TURN_HALF_UNITS;
        end else begin
            wrapped = h;
        end
        fold = 1'b0;
        if (wrapped > hvd_pkg::QUARTER_TURN) begin
            folded = wrapped - hvd_pkg::HALF_TURN;
            fold   = 1'b1;
        end else if (wrapped < -hvd_pkg::QUARTER_TURN) begin
            folded = wrapped + hvd_pkg::HALF_TURN;
            fold   = 1'b1;
        end else begin
            folded = wrapped;
        end
        mag_full = folded[hvd_pkg::WRAP_W-1] ? hvd_pkg::WRAP_W'(-folded)
                                             : hvd_pkg::WRAP_W'(folded);
    end

    // Round the scaled magnitude and restore the sign
    always_comb begin
        rnd_sum = 64'(r_b_prod) + 64'h0000_0000_8000_0000;
        z_init  = hvd_pkg::Z_W'(rnd_sum[63:32]);
        if (r_b_neg) begin
            z_init = -z_init;
        end
    end

    // Advance valid bits through the front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_v[0]    <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_v[0]    <= r_b_valid;
        end
    end

    // Hold the front stage payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_mag  <= mag_full[30:0];
            r_a_neg  <= folded[hvd_pkg::WRAP_W-1];
            r_a_fold <= fold;
            r_b_prod <= 63'(r_a_mag) * 63'(hvd_pkg::RAD_SCALE);
            r_b_neg  <= r_a_neg;
            r_b_fold <= r_a_fold;
            r_x[0]    <= hvd_pkg::CORDIC_GAIN;
            r_y[0]    <= '0;
            r_z[0]    <= z_init;
            r_fold[0] <= r_b_fold;
        end
    end

    // One micro-rotation per stage
    for (genvar i = 0; i < N; i++) begin : g_rot
        logic signed [hvd_pkg::XY_W-1:0] x_sh;
        logic signed [hvd_pkg::XY_W-1:0] y_sh;
        logic signed [hvd_pkg::Z_W-1:0]  ang;

        assign x_sh = r_x[i] >>> i;
        assign y_sh = r_y[i] >>> i;
        assign ang  = hvd_pkg::atan_q30(i);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (i_en) begin
                r_v[i+1] <= r_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_fold[i+1] <= r_fold[i];
                if (!r_z[i][hvd_pkg::Z_W-1]) begin
                    r_x[i+1] <= r_x[i] - y_sh;
                    r_y[i+1] <= r_y[i] + x_sh;
                    r_z[i+1] <= r_z[i] - ang;
                end else begin
                    r_x[i+1] <= r_x[i] + y_sh;
                    r_y[i+1] <= r_y[i] - x_sh;
                    r_z[i+1] <= r_z[i] + ang;
                end
            end
        end
    end

    // Undo the fold on the way out
    assign o_valid = r_v[N];
    assign o_sin   = r_fold[N] ? -r_y[N] : r_y[N];
    assign o_cos   = r_fold[N] ? -r_x[N] : r_x[N];

endmodule

// ===== hw/rtl/hvd_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvd_sqrt
// Pipelined digit-by-digit square root of a Q30 value, one result bit per
// stage. The result is floor(sqrt(op * 2^30)), again in Q30.
// ----------------------------------------------------------------------------
module hvd_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [hvd_pkg::OP_W-1:0]      i_op,
    output logic                          o_valid,
    output logic [hvd_pkg::ROOT_W-1:0]    o_root
);

    localparam int N = hvd_pkg::CORDIC_ITER;

    logic                          r_v    [0:N];
    logic [hvd_pkg::OP_W-1:0]      r_op   [0:N];
    logic [hvd_pkg::REM_W-1:0]     r_rem  [0:N];
    logic [hvd_pkg::ROOT_W-1:0]    r_root [0:N];

    // Load the operand
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_op[0]   <= i_op;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
        end
    end

    // One root bit per stage, two radicand bits taken in each
    for (genvar k = 0; k < N; k++) begin : g_digit
        logic [61:0]                  rad;
        logic [1:0]                   pair;
        logic [hvd_pkg::REM_W+1:0]    rem_sh;
        logic [hvd_pkg::REM_W+1:0]    trial;

        assign rad    = {1'b0, r_op[k], 30'b0};
        assign pair   = rad[61-2*k -: 2];
        assign rem_sh = {r_rem[k], pair};
        assign trial  = (hvd_pkg::REM_W+2)'({r_root[k], 2'b01});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_op[k+1] <= r_op[k];
                if (rem_sh >= trial) begin
                    r_rem[k+1]  <= hvd_pkg::REM_W'(rem_sh - trial);
                    r_root[k+1] <= {r_root[k][hvd_pkg::ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem[k+1]  <= hvd_pkg::REM_W'(rem_sh);
                    r_root[k+1] <= {r_root[k][hvd_pkg::ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_v[N];
    assign o_root  = r_root[N];

endmodule

// ===== hw/rtl/hvd_atan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvd_atan
// Pipelined vectoring CORDIC: drives y to zero and accumulates the angle
// atan2(y, x) in Q30, one micro-rotation per stage. A negative angle is
// clamped to zero.
// ----------------------------------------------------------------------------
module hvd_atan (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [hvd_pkg::ROOT_W-1:0]    i_x,
    input  logic [hvd_pkg::ROOT_W-1:0]    i_y,
    output logic                          o_valid,
    output logic [hvd_pkg::ANGLE_W-1:0]   o_angle
);

    localparam int N = hvd_pkg::CORDIC_ITER;

    logic                              r_v [0:N];
    logic signed [hvd_pkg::VXY_W-1:0]  r_x [0:N];
    logic signed [hvd_pkg::VXY_W-1:0]  r_y [0:N];
    logic signed [hvd_pkg::Z_W-1:0]    r_z [0:N];

    // Load the vector
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= hvd_pkg::VXY_W'({1'b0, i_x});
            r_y[0] <= hvd_pkg::VXY_W'({1'b0, i_y});
            r_z[0] <= '0;
        end
    end

    // Rotate towards the x axis
    for (genvar i = 0; i < N; i++) begin : g_vec
        logic signed [hvd_pkg::VXY_W-1:0] x_sh;
        logic signed [hvd_pkg::VXY_W-1:0] y_sh;
        logic signed [hvd_pkg::Z_W-1:0]   ang;

        assign x_sh = r_x[i] >>> i;
        assign y_sh = r_y[i] >>> i;
        assign ang  = hvd_pkg::atan_q30(i);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (i_en) begin
                r_v[i+1] <= r_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_y[i] > 0) begin
                    r_x[i+1] <= r_x[i] + y_sh;
                    r_y[i+1] <= r_y[i] - x_sh;
                    r_z[i+1] <= r_z[i] + ang;
                end else begin
                    r_x[i+1] <= r_x[i] - y_sh;
                    r_y[i+1] <= r_y[i] + x_sh;
                    r_z[i+1] <= r_z[i] - ang;
                end
            end
        end
    end

    // Clamp a negative angle to zero
    assign o_valid = r_v[N];
    assign o_angle = r_z[N][hvd_pkg::Z_W-1] ? '0 : r_z[N][hvd_pkg::ANGLE_W-1:0];

endmodule

// ===== hw/rtl/haversine_distance.sv =====
`timescale 1ns / 1ps
// Throughput: one word per cycle; every stage advances together and a
// stalled output freezes the whole pipeline without loss.
// Depth is set by the four 31-stage CORDIC lanes, the 31-stage square
// roots and the 31-stage vectoring CORDIC.
// Reset: synchronous, active low; clears all valid bits, radius -> 6371000.
// ----------------------------------------------------------------------------
// haversine_distance
// Great-circle distance between two positions by the haversine formula,
// fully pipelined fixed-point datapath with a configurable sphere radius.
// ----------------------------------------------------------------------------
module haversine_distance (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [30:0]                   i_first_latitude,
    input  logic signed [31:0]                   i_first_longitude,
    input  logic signed [30:0]                   i_second_latitude,
    input  logic signed [31:0]                   i_second_longitude,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [hvd_pkg::DIST_W-1:0]           o_distance_m,
    input  logic                                 i_cfg_wr_en,
    input  logic [hvd_pkg::RADIUS_W-1:0]         i_cfg_wr_data
);

    localparam int AW = hvd_pkg::ANG_W;
    localparam int XW = hvd_pkg::XY_W;

    logic en;

    logic [hvd_pkg::RADIUS_W-1:0] r_radius;

    logic                 r_s0_valid;
    logic signed [AW-1:0] r_ang_dphi;
    logic signed [AW-1:0] r_ang_dlam;
    logic signed [AW-1:0] r_ang_lat1;
    logic signed [AW-1:0] r_ang_lat2;

    logic                 sc_valid;
    logic signed [XW-1:0] s_dphi;
    logic signed [XW-1:0] s_dlam;
    logic signed [XW-1:0] c_lat1;
    logic signed [XW-1:0] c_lat2;

    logic                 r_p1_valid;
    logic signed [63:0]   r_p1_dphi;
    logic signed [63:0]   r_p1_cc;
    logic signed [63:0]   r_p1_dlam;

    logic                 r_p2_valid;
    logic signed [XW-1:0] r_p2_dphi;
    logic signed [XW-1:0] r_p2_cc;
    logic signed [XW-1:0] r_p2_dlam;

    logic                 r_p3_valid;
    logic signed [XW-1:0] r_p3_dphi;
    logic signed [63:0]   r_p3_prod;

    logic                        r_p4_valid;
    logic [hvd_pkg::OP_W-1:0]    r_p4_a;
    logic signed [XW:0]          a_sum;
    logic [hvd_pkg::OP_W-1:0]    a_clamped;
    logic [hvd_pkg::OP_W-1:0]    a_compl;

    logic                         sq_valid;
    logic [hvd_pkg::ROOT_W-1:0]   root_y;
    logic [hvd_pkg::ROOT_W-1:0]   root_x;

    logic                         at_valid;
    logic [hvd_pkg::ANGLE_W-1:0]  angle;

    logic                         r_f1_valid;
    logic [53:0]                  r_f1_prod;
    logic [54:0]                  f2_sum;
    logic [25:0]                  f2_dist;

    logic                         r_out_valid;
    logic [hvd_pkg::DIST_W-1:0]   r_distance;

    // Advance the whole pipeline unless the output word is stuck
    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en;

    // Radius register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= hvd_pkg::RADIUS_RESET;
        end else if (i_cfg_wr_en) begin
            r_radius <= i_cfg_wr_data;
        end
    end

    // Valid bits of the top-level stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid  <= 1'b0;
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_p3_valid  <= 1'b0;
            r_p4_valid  <= 1'b0;
            r_f1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s0_valid  <= i_in_valid;
            r_p1_valid  <= sc_valid;
            r_p2_valid  <= r_p1_valid;
            r_p3_valid  <= r_p2_valid;
            r_p4_valid  <= r_p3_valid;
            r_f1_valid  <= at_valid;
            r_out_valid <= r_f1_valid;
        end
    end

    // Form the half-angle differences and the doubled latitudes
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ang_dphi <= AW'(i_second_latitude) - AW'(i_first_latitude);
            r_ang_dlam <= AW'(i_second_longitude) - AW'(i_first_longitude);
            r_ang_lat1 <= AW'(i_first_latitude) <<< 1;
            r_ang_lat2 <= AW'(i_second_latitude) <<< 1;
        end
    end

    hvd_sincos u_sc_dphi (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s0_valid),
        .i_angle (r_ang_dphi),
        .o_valid (sc_valid),
        .o_sin   (s_dphi),
        .o_cos   ()
    );

    hvd_sincos u_sc_dlam (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s0_valid),
        .i_angle (r_ang_dlam),
        .o_valid (),
        .o_sin   (s_dlam),
        .o_cos   ()
    );

    hvd_sincos u_sc_lat1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s0_valid),
        .i_angle (r_ang_lat1),
        .o_valid (),
        .o_sin   (),
        .o_cos   (c_lat1)
    );

    hvd_sincos u_sc_lat2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s0_valid),
        .i_angle (r_ang_lat2),
        .o_valid (),
        .o_sin   (),
        .o_cos   (c_lat2)
    );

    // Combine into the haversine term over four stages
    always_comb begin
        a_sum = (XW+1)'(r_p3_dphi) + (XW+1)'(hvd_pkg::q30_round(r_p3_prod));
        if (a_sum[XW]) begin
            a_clamped = '0;
        end else if (a_sum > (XW+1)'(hvd_pkg::Q30_ONE)) begin
            a_clamped = hvd_pkg::Q30_ONE;
        end else begin
            a_clamped = a_sum[hvd_pkg::OP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1_dphi <= 64'(s_dphi * s_dphi);
            r_p1_cc   <= 64'(c_lat1 * c_lat2);
            r_p1_dlam <= 64'(s_dlam * s_dlam);
            r_p2_dphi <= hvd_pkg::q30_round(r_p1_dphi);
            r_p2_cc   <= hvd_pkg::q30_round(r_p1_cc);
            r_p2_dlam <= hvd_pkg::q30_round(r_p1_dlam);
            r_p3_dphi <= r_p2_dphi;
            r_p3_prod <= 64'(r_p2_cc * r_p2_dlam);
            r_p4_a    <= a_clamped;
        end
    end

    assign a_compl = hvd_pkg::Q30_ONE - r_p4_a;

    hvd_sqrt u_sqrt_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_p4_valid),
        .i_op    (r_p4_a),
        .o_valid (sq_valid),
        .o_root  (root_y)
    );

    hvd_sqrt u_sqrt_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_p4_valid),
        .i_op    (a_compl),
        .o_valid (),
        .o_root  (root_x)
    );

    hvd_atan u_atan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_valid),
        .i_x     (root_x),
        .i_y     (root_y),
        .o_valid (at_valid),
        .o_angle (angle)
    );

    // Scale by the radius, round to metres and saturate
    assign f2_sum  = 55'(r_f1_prod) + 55'd268435456;
    assign f2_dist = f2_sum[54:29];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1_prod <= 54'(angle) * 54'(r_radius);
            if (f2_dist[25]) begin
                r_distance <= hvd_pkg::DIST_MAX;
            end else begin
                r_distance <= f2_dist[hvd_pkg::DIST_W-1:0];
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_distance_m = r_distance;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives position pairs into the haversine distance pipeline under random
// bursts, gaps and output stalls, predicts each distance word with a local
// fixed-point model and compares every word in order. Covers several radius
// settings, coordinate extremes, wrapping and a long output hold-off.
// ----------------------------------------------------------------------------
module testbench;

    localparam int LATENCY     = 105;
    localparam int CYCLE_LIMIT = 1000000;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_in_valid;
    logic                                o_in_ready;
    logic signed [30:0]                  i_first_latitude;
    logic signed [31:0]                  i_first_longitude;
    logic signed [30:0]                  i_second_latitude;
    logic signed [31:0]                  i_second_longitude;
    logic                                o_out_valid;
    logic                                i_out_ready;
    logic [hvd_pkg::DIST_W-1:0]          o_distance_m;
    logic                                i_cfg_wr_en;
    logic [hvd_pkg::RADIUS_W-1:0]        i_cfg_wr_data;

    logic [hvd_pkg::RADIUS_W-1:0]        radius_m;
    logic [hvd_pkg::DIST_W-1:0]          distance_queue [$];
    int                                  error_count;
    int                                  cycle_count;
    int                                  hold_off_cycles;
    bit                                  stall_enable;

    haversine_distance dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_first_latitude   (i_first_latitude),
        .i_first_longitude  (i_first_longitude),
        .i_second_latitude  (i_second_latitude),
        .i_second_longitude (i_second_longitude),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_distance_m       (o_distance_m),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data)
    );

    // Clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Arithmetic right shift that floors
    function automatic longint shift_floor(input longint v, input int n);
        return v >>> n;
    endfunction

    function automatic longint atan_step(input int idx);
        longint tbl [10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                             33543516, 16775851, 8388437, 4194283, 2097149};
        if (idx < 10) begin
            return tbl[idx];
        end
        return longint'(1) << (30 - idx);
    endfunction

    // Q30 product, rounded half away from zero
    function automatic longint mul_round(input longint a, input longint b);
        longint p;
        p = a * b;
        if (p >= 0) begin
            return (p + (longint'(1) << 29)) >>> 30;
        end
        return -(((-p) + (longint'(1) << 29)) >>> 30);
    endfunction

    // Sine and cosine in Q30 of an angle in 5e-8 degree units
    task automatic sine_cosine(input longint h, output longint s, output longint c);
        longint r, z, x, y, xs, ys;
        longint unsigned mag;
        bit     neg;
        neg = 0;
        r = h % 64'sd7200000000;
        if (r < 0) r += 64'sd7200000000;
        if (r > 64'sd3600000000) r -= 64'sd7200000000;
        if (r > 64'sd1800000000) begin
            r -= 64'sd3600000000;
            neg = 1;
        end else if (r < -64'sd1800000000) begin
            r += 64'sd3600000000;
            neg = 1;
        end
        mag = (r < 0) ? -r : r;
        z = longint'((mag * 64'd4024455254 + (64'd1 << 31)) >> 32);
        if (r < 0) z = -z;
        x = 652032875;
        y = 0;
        for (int i = 0; i < hvd_pkg::CORDIC_ITER; i++) begin
            xs = shift_floor(x, i);
            ys = shift_floor(y, i);
            if (z >= 0) begin
                x -= ys; y += xs; z -= atan_step(i);
            end else begin
                x += ys; y -= xs; z += atan_step(i);
            end
        end
        s = neg ? -y : y;
        c = neg ? -x : x;
    endtask

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Expected distance in metres for one position pair
    task automatic predict_distance(input logic signed [30:0] lat1,
                                    input logic signed [31:0] lon1,
                                    input logic signed [30:0] lat2,
                                    input logic signed [31:0] lon2,
                                    output logic [hvd_pkg::DIST_W-1:0] want_dist);
        longint sdp, cdp, sdl, cdl, s1, c1, s2, c2, a, x, y, z, xs, ys;
        longint unsigned d;
        sine_cosine(longint'(lat2) - longint'(lat1), sdp, cdp);
        sine_cosine(longint'(lon2) - longint'(lon1), sdl, cdl);
        sine_cosine(2 * longint'(lat1), s1, c1);
        sine_cosine(2 * longint'(lat2), s2, c2);
        a = mul_round(sdp, sdp) + mul_round(mul_round(c1, c2), mul_round(sdl, sdl));
        if (a < 0) a = 0;
        if (a > 64'sd1073741824) a = 64'sd1073741824;
        y = longint'(int_sqrt(longint'(a) << 30));
        x = longint'(int_sqrt((64'sd1073741824 - a) << 30));
        z = 0;
        for (int i = 0; i < hvd_pkg::CORDIC_ITER; i++) begin
            xs = shift_floor(x, i);
            ys = shift_floor(y, i);
            if (y > 0) begin
                x += ys; y -= xs; z += atan_step(i);
            end else begin
                x -= ys; y += xs; z -= atan_step(i);
            end
        end
        if (z < 0) z = 0;
        d = (longint'(z) * 2 * longint'(radius_m) + (64'd1 << 29)) >> 30;
        if (d > 64'h1FFFFFF) d = 64'h1FFFFFF;
        want_dist = d[hvd_pkg::DIST_W-1:0];
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // Offer one word and hold it until accepted
    task automatic send_pair(input logic signed [30:0] lat1, input logic signed [31:0] lon1,
                             input logic signed [30:0] lat2, input logic signed [31:0] lon2);
        logic [hvd_pkg::DIST_W-1:0] want_dist;
        predict_distance(lat1, lon1, lat2, lon2, want_dist);
        i_in_valid         <= 1'b1;
        i_first_latitude   <= lat1;
        i_first_longitude  <= lon1;
        i_second_latitude  <= lat2;
        i_second_longitude <= lon2;
        do @(posedge i_clk); while (!o_in_ready);
        distance_queue.push_back(want_dist);
    endtask

    task automatic idle_sender(input int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Wait for every expected word, then let the pipeline drain
    task automatic drain();
        idle_sender(1);
        while (distance_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic write_radius(input logic [hvd_pkg::RADIUS_W-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        radius_m = value;
    endtask

    function automatic logic signed [30:0] rand_lat();
        return 31'(int'($urandom_range(0, 1800000000)) - 900000000);
    endfunction

    function automatic logic signed [31:0] rand_lon();
        return 32'(longint'($urandom_range(0, 2000000000)) * 9 / 5 - 64'sd1800000000);
    endfunction

    // Random burst sender: well-formed positions mostly, raw bits otherwise
    task automatic send_random(input int count);
        int sent;
        logic signed [30:0] la1, la2;
        logic signed [31:0] lo1, lo2;
        sent = 0;
        while (sent < count) begin
            for (int b = $urandom_range(1, 30); b > 0 && sent < count; b--) begin
                if ($urandom_range(0, 9) < 8) begin
                    la1 = rand_lat();
                    lo1 = rand_lon();
                    if ($urandom_range(0, 2) == 0) begin
                        // nearby point
                        la2 = la1 + 31'(int'($urandom_range(0, 2000)) - 1000);
                        lo2 = lo1 + 32'(int'($urandom_range(0, 2000)) - 1000);
                    end else begin
                        la2 = rand_lat();
                        lo2 = rand_lon();
                    end
                end else begin
                    la1 = 31'($urandom);
                    lo1 = $urandom;
                    la2 = 31'($urandom);
                    lo2 = $urandom;
                end
                send_pair(la1, lo1, la2, lo2);
                sent++;
            end
            if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 12));
        end
    endtask

    task automatic test_directed();
        send_pair(0, 0, 0, 0);
        send_pair(900000000, 0, -900000000, 0);
        send_pair(0, 0, 0, 1800000000);
        send_pair(0, -1800000000, 0, 1800000000);
        send_pair(-900000000, -1800000000, 900000000, 1800000000);
        send_pair(0, 0, 0, 1);
        send_pair(1, 0, 0, 0);
        send_pair(515000000, -1200000, 407000000, -740000000);
        send_pair(0, 0, 0, 1799999999);
        send_pair(450000000, 900000000, -450000000, -900000000);
        // out-of-range coordinates wrap
        send_pair(31'sh3FFFFFFF, 32'sh7FFFFFFF, 31'sh40000000, 32'sh80000000);
        send_pair(31'sh40000000, 32'sh80000000, 31'sh3FFFFFFF, 32'sh7FFFFFFF);
        send_pair(-31'sd1, -32'sd1, 31'sh2AAAAAAA, 32'h55555555);
        send_pair(31'sh15555555, 32'hAAAAAAAA, 0, 0);
        drain();
    endtask

    task automatic test_radius_settings();
        logic [hvd_pkg::RADIUS_W-1:0] radii [5] = '{23'd1000000, 23'd8388607, 23'd0,
                                                    23'd1, 23'd6371000};
        foreach (radii[k]) begin
            write_radius(radii[k]);
            send_pair(900000000, 0, -900000000, 0);
            send_pair(0, 0, 0, 1800000000);
            send_pair(0, 0, 0, 1);
            send_random(40);
            drain();
        end
        write_radius(23'($urandom_range(1000000, 8388607)));
    endtask

    task automatic test_random_traffic();
        send_random(1000);
        drain();
    endtask

    // Receiver holds off while the sender keeps offering words
    task automatic test_output_hold_off();
        hold_off_cycles = 400;
        send_random(250);
        drain();
    endtask

    // Receiver stall pattern, plus counted hold-off
    always @(posedge i_clk) begin
        if (hold_off_cycles > 0) begin
            i_out_ready     <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else if (stall_enable) begin
            i_out_ready <= ($urandom_range(0, 3) != 0) || cycle_count[9];
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Check each distance word against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (distance_queue.size() == 0) begin
                report_mismatch($sformatf("unexpected distance word %0d", o_distance_m));
            end else begin
                logic [hvd_pkg::DIST_W-1:0] want;
                want = distance_queue.pop_front();
                if (o_distance_m !== want)
                    report_mismatch($sformatf("distance_m got %0d want %0d",
                                              o_distance_m, want));
            end
        end
    end

    // Timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        i_in_valid         = 1'b0;
        i_out_ready        = 1'b0;
        i_first_latitude   = '0;
        i_first_longitude  = '0;
        i_second_latitude  = '0;
        i_second_longitude = '0;
        i_cfg_wr_en        = 1'b0;
        i_cfg_wr_data      = '0;
        error_count        = 0;
        cycle_count        = 0;
        hold_off_cycles    = 0;
        stall_enable       = 1'b0;
        radius_m           = hvd_pkg::RADIUS_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        stall_enable = 1'b1;
        test_radius_settings();
        test_random_traffic();
        test_output_hold_off();

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
